@@ rtl/lfpr_pkg.sv @@
// Shared types, sequencer codes and control store of the length-framed packet receiver.
package lfpr_pkg;

	localparam int UPC_W = 2;

	localparam logic [1:0] COND_NEVER   = 2'd0;
	localparam logic [1:0] COND_ALWAYS  = 2'd1;
	localparam logic [1:0] COND_NO_EMIT = 2'd2;
	localparam logic [1:0] COND_LAST    = 2'd3;

	localparam logic [UPC_W-1:0] UPC_WAIT = 2'd0;
	localparam logic [UPC_W-1:0] UPC_READ = 2'd1;
	localparam logic [UPC_W-1:0] UPC_LOAD = 2'd2;
	localparam logic [UPC_W-1:0] UPC_LOOP = 2'd3;

	typedef struct packed {
		logic             take;
		logic             load;
		logic             hold;
		logic [1:0]       cond;
		logic [UPC_W-1:0] target;
	} ucw_t;

	typedef struct packed {
		logic emit_start;
		logic out_free;
		logic last;
	} useq_stat_t;

	function automatic ucw_t ucode_rom(input logic [UPC_W-1:0] upc);
		ucw_t w;
		unique case (upc)
			UPC_WAIT: w = '{take: 1'b1, load: 1'b0, hold: 1'b0,
			                cond: COND_NO_EMIT, target: UPC_WAIT};
			UPC_READ: w = '{take: 1'b0, load: 1'b0, hold: 1'b0,
			                cond: COND_NEVER, target: UPC_WAIT};
			UPC_LOAD: w = '{take: 1'b0, load: 1'b1, hold: 1'b1,
			                cond: COND_LAST, target: UPC_WAIT};
			UPC_LOOP: w = '{take: 1'b0, load: 1'b0, hold: 1'b0,
			                cond: COND_ALWAYS, target: UPC_READ};
			default:  w = '{take: 1'b0, load: 1'b0, hold: 1'b0,
			                cond: COND_ALWAYS, target: UPC_WAIT};
		endcase
		return w;
	endfunction

endpackage

@@ rtl/lfpr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lfpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/lfpr_useq.sv @@
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module lfpr_useq (
	input  logic               clk,
	input  logic               arst_n,
	input  lfpr_pkg::useq_stat_t stat,
	output lfpr_pkg::ucw_t     uword
);
	import lfpr_pkg::*;

	logic [UPC_W-1:0] upc_q;
	logic             cond_hit;

	assign uword = ucode_rom(upc_q);

	always_comb begin
		unique case (uword.cond)
			COND_NEVER:   cond_hit = 1'b0;
			COND_ALWAYS:  cond_hit = 1'b1;
			COND_NO_EMIT: cond_hit = !stat.emit_start;
			COND_LAST:    cond_hit = stat.last;
			default:      cond_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UPC_WAIT;
		end else if (uword.hold && !stat.out_free) begin
			upc_q <= upc_q;
		end else if (cond_hit) begin
			upc_q <= uword.target;
		end else begin
			upc_q <= upc_q + 1'b1;
		end
	end

endmodule

@@ rtl/length_framed_packet_receiver_unit.sv @@
// Top level of the length-framed packet receiver with XOR checksum.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid/in_ready, cmd, rx_byte           | to block
//  out     | out_valid/out_ready, command, packet_id,  | from block
//          | payload_length, byte_index, payload_byte, |
//          | last                                      |
//  cfg     | cfg_we, cfg_wdata (timeout_ticks)         | to block
//
// A byte or tick item is taken with no stall when no frame ends on it.
// After a good frame end each result takes the read, load and loop steps (the last
// skips the loop step), taking no item; a waiting result never blocks the next item.
// Output stalls hold the load step of the loop.
// Reset clears the parser, the sequencer and the output valid; timeout_ticks resets to 40.
module length_framed_packet_receiver_unit #(
	parameter int DATA_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  command,
	output logic [7:0]  packet_id,
	output logic [4:0]  payload_length,
	output logic [4:0]  byte_index,
	output logic [7:0]  payload_byte,
	output logic        last,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	import lfpr_pkg::*;

	localparam int AW = $clog2(DATA_DEPTH);
	localparam int CW = $clog2(DATA_DEPTH + 1);

	localparam logic [2:0] PH_LENGTH  = 3'd0;
	localparam logic [2:0] PH_COMPL   = 3'd1;
	localparam logic [2:0] PH_COMMAND = 3'd2;
	localparam logic [2:0] PH_ID      = 3'd3;
	localparam logic [2:0] PH_DATA    = 3'd4;

	logic [15:0]   timeout_q;
	logic [2:0]    phase_q;
	logic [7:0]    len_q;
	logic [7:0]    cmd_q;
	logic [7:0]    id_q;
	logic [CW-1:0] rcv_cnt_q;
	logic [7:0]    xor_q;
	logic [15:0]   sil_q;

	logic [7:0]    emit_cmd_q;
	logic [7:0]    emit_id_q;
	logic [AW-1:0] emit_plen_q;
	logic [AW-1:0] emit_k_q;

	logic          out_valid_q;
	logic [7:0]    out_cmd_q;
	logic [7:0]    out_id_q;
	logic [4:0]    out_plen_q;
	logic [4:0]    out_idx_q;
	logic [7:0]    out_byte_q;
	logic          out_last_q;

	ucw_t          uword;
	useq_stat_t    stat;

	logic          accept;
	logic          is_byte;
	logic          is_tick;
	logic          store_ok;
	logic [CW-1:0] cnt_next;
	logic [7:0]    xor_next;
	logic          frame_end;
	logic          emit_start;
	logic [15:0]   sil_inc;
	logic          out_free;
	logic          load_fire;
	logic [AW-1:0] emit_n;
	logic          emit_last;
	logic [7:0]    ram_rdata;
	logic [7:0]    plen_ext;
	logic [7:0]    k_ext;

	assign accept    = in_valid && uword.take;
	assign is_byte   = accept && !cmd;
	assign is_tick   = accept && cmd;
	assign store_ok  = (phase_q == PH_DATA) && (rcv_cnt_q < CW'(DATA_DEPTH));
	assign cnt_next  = rcv_cnt_q + 1'b1;
	assign xor_next  = xor_q ^ rx_byte;
	assign frame_end = (9'(cnt_next) + 9'd2) >= {1'b0, len_q};
	assign emit_start = is_byte && store_ok && frame_end && (xor_next == 8'h00);
	assign sil_inc   = (sil_q == 16'hffff) ? sil_q : sil_q + 16'd1;

	assign out_free  = !out_valid_q || out_ready;
	assign load_fire = uword.load && out_free;
	assign emit_n    = (emit_plen_q == '0) ? AW'(1) : emit_plen_q;
	assign emit_last = (emit_k_q == emit_n - 1'b1);

	assign stat = '{emit_start: emit_start, out_free: out_free, last: emit_last};

	lfpr_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.uword  (uword)
	);

	lfpr_ram #(
		.WIDTH (8),
		.DEPTH (DATA_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (is_byte && store_ok),
		.waddr (rcv_cnt_q[AW-1:0]),
		.wdata (rx_byte),
		.raddr (emit_k_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 16'd40;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_LENGTH;
			rcv_cnt_q <= '0;
			xor_q     <= '0;
			sil_q     <= '0;
		end else if (is_tick) begin
			if (phase_q != PH_LENGTH) begin
				if (sil_inc >= timeout_q) begin
					phase_q   <= PH_LENGTH;
					rcv_cnt_q <= '0;
					xor_q     <= '0;
					sil_q     <= '0;
				end else begin
					sil_q <= sil_inc;
				end
			end
		end else if (is_byte) begin
			unique case (phase_q)
				PH_LENGTH: begin
					phase_q <= PH_COMPL;
					sil_q   <= '0;
				end
				PH_COMPL: begin
					if ((~rx_byte == len_q) && (len_q >= 8'd3)) begin
						phase_q <= PH_COMMAND;
					end else begin
						phase_q <= PH_LENGTH;
					end
					sil_q <= '0;
				end
				PH_COMMAND: begin
					xor_q   <= rx_byte;
					phase_q <= PH_ID;
					sil_q   <= '0;
				end
				PH_ID: begin
					xor_q   <= xor_next;
					phase_q <= PH_DATA;
					sil_q   <= '0;
				end
				PH_DATA: begin
					if (store_ok) begin
						sil_q <= '0;
						if (frame_end) begin
							phase_q   <= PH_LENGTH;
							rcv_cnt_q <= '0;
							xor_q     <= '0;
						end else begin
							rcv_cnt_q <= cnt_next;
							xor_q     <= xor_next;
						end
					end
				end
				default: begin
					phase_q   <= PH_LENGTH;
					rcv_cnt_q <= '0;
					xor_q     <= '0;
					sil_q     <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (is_byte) begin
			if (phase_q == PH_LENGTH) begin
				len_q <= rx_byte;
			end
			if (phase_q == PH_COMMAND) begin
				cmd_q <= rx_byte;
			end
			if (phase_q == PH_ID) begin
				id_q <= rx_byte;
			end
		end
		if (emit_start) begin
			emit_cmd_q  <= cmd_q;
			emit_id_q   <= id_q;
			emit_plen_q <= rcv_cnt_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_k_q <= '0;
		end else if (emit_start) begin
			emit_k_q <= '0;
		end else if (load_fire) begin
			emit_k_q <= emit_k_q + 1'b1;
		end
	end

	assign plen_ext = 8'(emit_plen_q);
	assign k_ext    = 8'(emit_k_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_fire) begin
			out_cmd_q  <= emit_cmd_q;
			out_id_q   <= emit_id_q;
			out_plen_q <= plen_ext[4:0];
			out_idx_q  <= (emit_plen_q == '0) ? 5'd0 : k_ext[4:0];
			out_byte_q <= (emit_plen_q == '0) ? 8'd0 : ram_rdata;
			out_last_q <= emit_last;
		end
	end

	assign in_ready       = uword.take;
	assign out_valid      = out_valid_q;
	assign command        = out_cmd_q;
	assign packet_id      = out_id_q;
	assign payload_length = out_plen_q;
	assign byte_index     = out_idx_q;
	assign payload_byte   = out_byte_q;
	assign last           = out_last_q;

	a_emit_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		emit_start |=> !in_ready)
		else $error("input taken during frame emission");

	a_idle_parser_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LENGTH) |-> (sil_q == 16'd0 && rcv_cnt_q == '0 && xor_q == 8'h00))
		else $error("parser state not cleared while waiting for length");

	a_emit_after_drop: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (phase_q == PH_LENGTH))
		else $error("emission while a frame is being parsed");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		load_fire |-> (emit_k_q < emit_n))
		else $error("payload index beyond frame length");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rcv_cnt_q <= CW'(DATA_DEPTH))
		else $error("received count beyond payload store");

endmodule
